@@ rtl/scq_pkg.sv @@
// Shared types and character constants for the shell string quoter.
package scq_pkg;

    localparam int MaxBytes  = 6;
    localparam int CntW      = 3;
    localparam int QDepth    = 4;
    localparam int QPtrW     = 2;
    localparam int QCntW     = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_NONE   = 8'h00;

    // Output bytes of one input item, first byte in slot 0.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [CntW-1:0]          cnt;
    } desc_t;

    typedef struct packed {
        logic  push;
        desc_t desc;
    } q_push_t;

    typedef struct packed {
        logic  empty;
        desc_t head;
    } q_head_t;

    // Letter for the short escapes, CH_NONE when the byte goes out in octal.
    function automatic logic [7:0] esc_letter(input logic [7:0] c);
        logic [7:0] l;
        unique case (c)
            8'h07:   l = 8'h61; // a
            8'h08:   l = 8'h62; // b
            8'h0C:   l = 8'h66; // f
            8'h0A:   l = 8'h6E; // n
            8'h0D:   l = 8'h72; // r
            8'h09:   l = 8'h74; // t
            CH_ESC:  l = 8'h65; // e
            default: l = CH_NONE;
        endcase
        return l;
    endfunction

endpackage

@@ rtl/scq_front.sv @@
// Front end: classifies each input item and builds its output bytes.
module scq_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            char_byte,
    input  logic                  end_mark,
    output scq_pkg::q_push_t      push_o
);

    typedef enum logic [1:0] {
        MODE_BEGIN    = 2'd0,
        MODE_QUOTED   = 2'd1,
        MODE_UNQUOTED = 2'd2
    } mode_t;

    mode_t mode_reg, mode_next;
    scq_pkg::desc_t desc;

    always_comb begin
        logic [scq_pkg::CntW-1:0] n;
        logic [7:0]               letter;
        logic                     printable;
        n          = '0;
        desc.bytes = '0;
        letter     = scq_pkg::esc_letter(char_byte);
        printable  = (char_byte >= 8'h20) && (char_byte <= 8'h7E);
        mode_next  = mode_reg;
        if (end_mark) begin
            if (mode_reg == MODE_BEGIN) begin
                desc.bytes[0] = scq_pkg::CH_QUOTE;
                desc.bytes[1] = scq_pkg::CH_QUOTE;
                n = 3'd2;
            end else if (mode_reg == MODE_QUOTED) begin
                desc.bytes[0] = scq_pkg::CH_QUOTE;
                n = 3'd1;
            end
            mode_next = MODE_BEGIN;
        end else if (!printable) begin
            if (mode_reg == MODE_QUOTED) begin
                desc.bytes[n] = scq_pkg::CH_QUOTE;
                n = n + 3'd1;
            end
            if (mode_reg != MODE_BEGIN) begin
                desc.bytes[n] = scq_pkg::CH_CARET;
                n = n + 3'd1;
            end
            desc.bytes[n] = scq_pkg::CH_BSLASH;
            n = n + 3'd1;
            if (letter != scq_pkg::CH_NONE) begin
                desc.bytes[n] = letter;
                n = n + 3'd1;
            end else begin
                if (char_byte >= 8'd64) begin
                    desc.bytes[n] = scq_pkg::CH_ZERO + {6'd0, char_byte[7:6]};
                    n = n + 3'd1;
                end
                if (char_byte >= 8'd8) begin
                    desc.bytes[n] = scq_pkg::CH_ZERO + {5'd0, char_byte[5:3]};
                    n = n + 3'd1;
                end
                desc.bytes[n] = scq_pkg::CH_ZERO + {5'd0, char_byte[2:0]};
                n = n + 3'd1;
            end
            mode_next = MODE_UNQUOTED;
        end else begin
            if (mode_reg != MODE_BEGIN && mode_reg != MODE_QUOTED) begin
                desc.bytes[n] = scq_pkg::CH_CARET;
                n = n + 3'd1;
            end
            if (mode_reg != MODE_QUOTED) begin
                desc.bytes[n] = scq_pkg::CH_QUOTE;
                n = n + 3'd1;
            end
            if (char_byte == scq_pkg::CH_QUOTE) begin
                desc.bytes[n] = scq_pkg::CH_QUOTE;
                n = n + 3'd1;
            end
            desc.bytes[n] = char_byte;
            n = n + 3'd1;
            mode_next = MODE_QUOTED;
        end
        desc.cnt = n;
    end

    // An end item after an escape makes no bytes and takes no queue slot.
    assign push_o.push = accept && (desc.cnt != '0);
    assign push_o.desc = desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BEGIN;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

endmodule

@@ rtl/scq_queue.sv @@
// Small queue of per-item byte groups between front and back end.
module scq_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  scq_pkg::q_push_t  push_i,
    input  logic              pop,
    output scq_pkg::q_head_t  head_o,
    output logic              full
);

    scq_pkg::desc_t mem [scq_pkg::QDepth];
    logic [scq_pkg::QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [scq_pkg::QCntW-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full         = (cnt_reg == scq_pkg::QCntW'(scq_pkg::QDepth));
    assign head_o.empty = (cnt_reg == '0);
    assign head_o.head  = mem[rd_ptr_reg];
    assign do_push      = push_i.push && !full;
    assign do_pop       = pop && !head_o.empty;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_i.desc;
        end
    end

endmodule

@@ rtl/scq_back.sv @@
// Back end: shifts the queued byte groups out one byte per item.
module scq_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  scq_pkg::q_head_t  head_i,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    logic [scq_pkg::MaxBytes-1:0][7:0] bytes_reg, bytes_next;
    logic [scq_pkg::CntW-1:0]          cnt_reg, cnt_next;
    logic                              valid_reg, valid_next;
    logic                              out_fire, need_load;

    assign m_tvalid  = valid_reg;
    assign m_tdata   = bytes_reg[0];
    assign m_tlast   = (cnt_reg == scq_pkg::CntW'(1));
    assign out_fire  = valid_reg && m_tready;
    assign need_load = !valid_reg || (out_fire && m_tlast);
    assign pop       = need_load && !head_i.empty;

    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (pop) begin
            bytes_next = head_i.head.bytes;
            cnt_next   = head_i.head.cnt;
            valid_next = 1'b1;
        end else if (need_load) begin
            valid_next = 1'b0;
        end else if (out_fire) begin
            bytes_next = {8'd0, bytes_reg[scq_pkg::MaxBytes-1:1]};
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        bytes_reg <= bytes_next;
        cnt_reg   <= cnt_next;
    end

endmodule

@@ rtl/shell_string_quoter.sv @@
// Top level of the shell string quoter.
//
// Input stream (s_*): one string byte per item in s_tdata, or an end item with
// s_tuser high (s_tdata ignored). Output stream (m_*): one quoted-text byte per
// item in m_tdata; m_tlast marks the final byte caused by one input item.
// Printable bytes go into single-quoted runs, other bytes go out as ^-joined
// backslash escapes; the end item closes the quoting and restarts.
//
// Each input item turns into 0 to 6 output bytes in the front end in the cycle
// it is accepted and lands in a four-entry queue. The back end shifts bytes out
// at one per cycle while m_tready is high; an item's bytes are registered in the
// queue and then in the back end's output register. Input is taken one item per
// cycle while the queue has room; sustained input is bounded by the bytes made
// per item, set by the single output byte per cycle of the back end. An end item
// after an escape makes no bytes.
//
// Reset (aresetn low, synchronous) empties the queue and the output register and
// returns the quoting state to the string start. When m_tready is low the
// current byte holds, the queue fills, and s_tready drops once it is full.
module shell_string_quoter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tuser,   // [0] end_mark
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    scq_pkg::q_push_t push;
    scq_pkg::q_head_t head;
    logic             full, pop, accept;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    scq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .char_byte (s_tdata),
        .end_mark  (s_tuser),
        .push_o    (push)
    );

    scq_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .pop     (pop),
        .head_o  (head),
        .full    (full)
    );

    scq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_i   (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/scq_checker.sv @@
// Port-level checks for the shell string quoter, bound to the top level.
module scq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Nothing comes out in the first cycle out of reset.
    a_no_out_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    // The queue is empty after reset, so input is open.
    a_ready_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> s_tready)
        else $error("input not ready after reset");

    // Quoted text is made of printable bytes only.
    a_out_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= 8'h20) && (m_tdata <= 8'h7E))
        else $error("non-printable output byte");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input item changed while waiting");

endmodule

bind shell_string_quoter scq_checker u_scq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/quote_checker.sv @@
// Stream checker for the shell string quoter: predicts quoted bytes and compares them.
module quote_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tuser,   // [0] end_mark
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,
    output int         err_count,
    output int         pending
);

    typedef enum logic [1:0] {
        AT_START  = 2'd0,
        IN_QUOTE  = 2'd1,
        AFTER_ESC = 2'd2
    } quote_state_t;

    typedef struct packed {
        logic [7:0] text;
        logic       tail;
    } quoted_byte_t;

    quote_state_t qstate = AT_START;
    quoted_byte_t quoted_q [$];

    task automatic report_mismatch(input string msg);
        $display("quote_checker: mismatch: %s", msg);
        err_count++;
    endtask

    // Quoted bytes caused by one input item, queued in output order.
    function automatic void predict_item(input logic [7:0] c, input logic fin);
        logic [7:0] seq [$];
        logic [7:0] letter;
        letter = scq_pkg::CH_NONE;
        if (fin) begin
            if (qstate == AT_START) begin
                seq.push_back(scq_pkg::CH_QUOTE);
                seq.push_back(scq_pkg::CH_QUOTE);
            end else if (qstate == IN_QUOTE) begin
                seq.push_back(scq_pkg::CH_QUOTE);
            end
            qstate = AT_START;
        end else if (c < 8'h20 || c > 8'h7E) begin
            if (qstate == IN_QUOTE)
                seq.push_back(scq_pkg::CH_QUOTE);
            if (qstate != AT_START)
                seq.push_back(scq_pkg::CH_CARET);
            seq.push_back(scq_pkg::CH_BSLASH);
            case (c)
                8'h07:           letter = "a";
                8'h08:           letter = "b";
                8'h0C:           letter = "f";
                8'h0A:           letter = "n";
                8'h0D:           letter = "r";
                8'h09:           letter = "t";
                scq_pkg::CH_ESC: letter = "e";
                default:         letter = scq_pkg::CH_NONE;
            endcase
            if (letter != scq_pkg::CH_NONE) begin
                seq.push_back(letter);
            end else begin
                // octal without leading zeros
                if (c >= 8'd64)
                    seq.push_back(scq_pkg::CH_ZERO + 8'(c[7:6]));
                if (c >= 8'd8)
                    seq.push_back(scq_pkg::CH_ZERO + 8'(c[5:3]));
                seq.push_back(scq_pkg::CH_ZERO + 8'(c[2:0]));
            end
            qstate = AFTER_ESC;
        end else begin
            if (qstate == AFTER_ESC)
                seq.push_back(scq_pkg::CH_CARET);
            if (qstate != IN_QUOTE)
                seq.push_back(scq_pkg::CH_QUOTE);
            if (c == scq_pkg::CH_QUOTE)
                seq.push_back(scq_pkg::CH_QUOTE);
            seq.push_back(c);
            qstate = IN_QUOTE;
        end
        foreach (seq[i])
            quoted_q.push_back('{text: seq[i], tail: (i == seq.size() - 1)});
    endfunction

    always @(posedge aclk) begin
        quoted_byte_t want;
        if (!aresetn) begin
            quoted_q.delete();
            qstate    = AT_START;
            err_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (quoted_q.size() == 0) begin
                    report_mismatch($sformatf("byte %h (last %b) with nothing expected",
                                              m_tdata, m_tlast));
                end else begin
                    want = quoted_q.pop_front();
                    if (m_tdata !== want.text)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  m_tdata, want.text));
                    if (m_tlast !== want.tail)
                        report_mismatch($sformatf("last_of_run %b on byte %h, expected %b",
                                                  m_tlast, m_tdata, want.tail));
                end
            end
        end
        pending <= quoted_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the shell string quoter: clock, reset, stimulus and verdict.
module tb_top;

    localparam int CycleLimit = 200000;
    localparam int TailCycles = 24;
    localparam int RandItems  = 310;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int err_count;
    int pending;
    int cycle_cnt = 0;
    int sent      = 0;
    bit gaps_on   = 1'b1;

    initial begin
        forever #1 aclk = ~aclk;
    end

    shell_string_quoter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    quote_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .err_count (err_count),
        .pending   (pending)
    );

    always @(posedge aclk)
        m_tready <= gaps_on ? ($urandom_range(0, 99) >= 25) : 1'b1;

    // One input item; returns at the edge where it was taken.
    task automatic put_item(input logic [7:0] b, input logic fin);
        while (gaps_on && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'($urandom_range(8'h20, 8'h7E));
        else if (r < 55)
            return scq_pkg::CH_QUOTE;
        else if (r < 80)
            return 8'($urandom_range(0, 31));
        else if (r < 84)
            return 8'h7F;
        else
            return 8'($urandom_range(128, 255));
    endfunction

    initial begin
        int len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty string, then an end right after an escape
        put_item(8'hFF, 1'b1);
        put_item(8'h00, 1'b0);
        put_item(8'h5A, 1'b1);
        // printable edges and a doubled quote
        put_item(8'h20, 1'b0);
        put_item(scq_pkg::CH_QUOTE, 1'b0);
        put_item(8'h7E, 1'b0);
        // byte >= 0o100 inside a quoted run: six bytes out
        put_item(8'hFF, 1'b0);
        put_item(8'h7F, 1'b0);
        put_item(8'h80, 1'b0);
        put_item(8'h1F, 1'b0);
        put_item(8'h10, 1'b0);
        put_item(8'h01, 1'b0);
        // short escapes
        put_item(8'h07, 1'b0);
        put_item(8'h08, 1'b0);
        put_item(8'h0C, 1'b0);
        put_item(8'h0A, 1'b0);
        put_item(8'h0D, 1'b0);
        put_item(8'h09, 1'b0);
        put_item(scq_pkg::CH_ESC, 1'b0);
        // back to quoted after an escape, close the run
        put_item(8'h41, 1'b0);
        put_item(8'h00, 1'b1);
        put_item(scq_pkg::CH_QUOTE, 1'b0);
        put_item(8'hAA, 1'b1);

        while (sent < RandItems) begin
            gaps_on = !(sent >= 120 && sent < 200);
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            repeat (len)
                put_item(pick_char(), 1'b0);
            put_item(8'($urandom), 1'b1);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        while (cycle_cnt < CycleLimit) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/scq_pkg.sv
rtl/scq_front.sv
rtl/scq_queue.sv
rtl/scq_back.sv
rtl/shell_string_quoter.sv
rtl/scq_checker.sv
tb/quote_checker.sv
tb/tb_top.sv
